>>> design/lpr_pkg.sv
// shared types and constants for the line point rasterizer
`timescale 1ns / 1ps

package lpr_pkg;

    // field widths fixed by the interface
    localparam int COORD_W = 6;
    localparam int COLOR_W = 32;
    localparam int CANVAS_W = 7;
    // error term width, holds twice the largest step plus sign
    localparam int ERR_W = 9;

    // configuration register indexes
    localparam logic [0:0] CFG_CANVAS_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_CANVAS_HEIGHT = 1'b1;

    // one line command on the input channel
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0] line_color;
    } in_word_t;

    // one emitted point on the result channel
    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               inside_res;
        logic [COLOR_W-1:0] point_color;
        logic               last;
    } out_word_t;

    // classified command handed from front to walker
    typedef struct packed {
        logic [COORD_W-1:0]      start_x;
        logic [COORD_W-1:0]      start_y;
        logic [COORD_W-1:0]      end_x;
        logic [COORD_W-1:0]      end_y;
        logic signed [ERR_W-1:0] dx;
        logic signed [ERR_W-1:0] dy;
        logic                    x_inc;
        logic                    y_inc;
        logic [COLOR_W-1:0]      color;
    } cmd_t;

    // canvas size for the inside test
    typedef struct packed {
        logic [CANVAS_W-1:0] width;
        logic [CANVAS_W-1:0] height;
    } canvas_t;

endpackage

>>> design/lpr_front.sv
// front end: masks endpoints and works out deltas and step directions
`timescale 1ns / 1ps

module lpr_front #(
    parameter int COORD_BITS = 6
) (
    input  lpr_pkg::in_word_t s_word,
    output lpr_pkg::cmd_t     cmd
);

    localparam logic [lpr_pkg::COORD_W-1:0] COORD_MASK =
        lpr_pkg::COORD_W'((1 << COORD_BITS) - 1);
    localparam int PAD_W = lpr_pkg::ERR_W - lpr_pkg::COORD_W;

    logic [lpr_pkg::COORD_W-1:0] sx, sy, ex, ey;
    logic [lpr_pkg::COORD_W-1:0] adx, ady;

    // endpoints taken modulo the coordinate range
    assign sx = s_word.start_x & COORD_MASK;
    assign sy = s_word.start_y & COORD_MASK;
    assign ex = s_word.end_x & COORD_MASK;
    assign ey = s_word.end_y & COORD_MASK;

    // absolute differences
    assign adx = (ex > sx) ? (ex - sx) : (sx - ex);
    assign ady = (ey > sy) ? (ey - sy) : (sy - ey);

    // classified command, dy carried negative
    always_comb begin
        cmd.start_x = sx;
        cmd.start_y = sy;
        cmd.end_x   = ex;
        cmd.end_y   = ey;
        cmd.dx      = $signed({{PAD_W{1'b0}}, adx});
        cmd.dy      = -$signed({{PAD_W{1'b0}}, ady});
        cmd.x_inc   = (sx < ex);
        cmd.y_inc   = (sy < ey);
        cmd.color   = s_word.line_color;
    end

endmodule

>>> design/lpr_queue.sv
// two-entry command queue between front end and walker
`timescale 1ns / 1ps

module lpr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lpr_pkg::cmd_t push_word,
    output logic          not_full,
    input  logic          pop,
    output logic          not_empty,
    output lpr_pkg::cmd_t pop_word
);

    lpr_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_word  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("queue fill count beyond depth");
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> not_empty)
        else $error("pushed word not visible in queue");
`endif

endmodule

>>> design/lpr_walk.sv
// back end: walks the error-term line and emits one point per cycle while the output slot is free
`timescale 1ns / 1ps

module lpr_walk (
    input  logic               aclk,
    input  logic               aresetn,
    input  lpr_pkg::canvas_t   canvas,
    input  logic               q_valid,
    input  lpr_pkg::cmd_t      q_word,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output lpr_pkg::out_word_t m_word
);

    localparam int CW = lpr_pkg::COORD_W;
    localparam int EW = lpr_pkg::ERR_W;

    logic                   busy_reg, busy_next;
    logic                   m_valid_reg, m_valid_next;
    lpr_pkg::out_word_t     m_word_reg, m_word_next;
    lpr_pkg::cmd_t          cmd_reg, cmd_next;
    logic [CW-1:0]          px_reg, px_next;
    logic [CW-1:0]          py_reg, py_next;
    logic signed [EW-1:0]   err_reg, err_next;

    logic signed [EW:0]     e2;
    logic                   step_x, step_y, done, in_canvas;
    logic signed [EW-1:0]   add_x, add_y;

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // error-term decisions for the current point
    assign e2     = {err_reg, 1'b0};
    assign step_x = (e2 >= $signed({cmd_reg.dy[EW-1], cmd_reg.dy}));
    assign step_y = (e2 <= $signed({cmd_reg.dx[EW-1], cmd_reg.dx}));
    assign add_x  = step_x ? cmd_reg.dy : '0;
    assign add_y  = step_y ? cmd_reg.dx : '0;
    assign done   = (px_reg == cmd_reg.end_x) && (py_reg == cmd_reg.end_y);
    assign in_canvas = ({1'b0, px_reg} < canvas.width) && ({1'b0, py_reg} < canvas.height);

    // load a command, then emit and step while the output slot is free
    always_comb begin
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        cmd_next     = cmd_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        err_next     = err_reg;
        q_pop        = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (!busy_reg) begin
            if (q_valid) begin
                q_pop     = 1'b1;
                busy_next = 1'b1;
                cmd_next  = q_word;
                px_next   = q_word.start_x;
                py_next   = q_word.start_y;
                err_next  = q_word.dx + q_word.dy;
            end
        end else if (!m_valid_reg || m_ready) begin
            m_valid_next            = 1'b1;
            m_word_next.point_x     = px_reg;
            m_word_next.point_y     = py_reg;
            m_word_next.inside_res  = in_canvas;
            m_word_next.point_color = cmd_reg.color;
            m_word_next.last        = done;
            if (done) begin
                busy_next = 1'b0;
            end else begin
                err_next = err_reg + add_x + add_y;
                if (step_x) begin
                    px_next = cmd_reg.x_inc ? px_reg + 1'b1 : px_reg - 1'b1;
                end
                if (step_y) begin
                    py_next = cmd_reg.y_inc ? py_reg + 1'b1 : py_reg - 1'b1;
                end
            end
        end
    end

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // walk state and output word
    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
        cmd_reg    <= cmd_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        err_reg    <= err_next;
    end

`ifndef NO_ASSERTIONS
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !busy_reg)
        else $error("command taken while a line is still being walked");
    a_end_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(busy_reg) |-> m_valid_reg && m_word_reg.last)
        else $error("line finished without a last point");
    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_word_reg.last && !busy_reg |->
            m_word_reg.point_x == cmd_reg.end_x && m_word_reg.point_y == cmd_reg.end_y)
        else $error("last point differs from end point");
`endif

endmodule

>>> design/line_point_rasterizer.sv
// top level of the line point rasterizer: config registers, front end, queue, walker
//
//  channel | ports                           | word
//  --------+---------------------------------+----------------------------------
//  input   | s_valid, s_ready, s_word        | line command (endpoints, colour)
//  result  | m_valid, m_ready, m_word        | one point with inside flag, last
//  config  | cfg_valid, cfg_ready, cfg_index | canvas width / height, cfg_data
//
// for a line of N = max(|dx|,|dy|)+1 points the walker first loads the command from
// the queue, then emits one point per cycle from the step loop while the output slot is free
// the front end classifies a command in the accepting cycle; two commands can wait
// in the queue while a line is walked, so s_ready drops only when it is full
// a stalled result holds the walker; reset empties the queue and drops any line
// canvas registers reset to 64 by 64 and are always ready for a write
`timescale 1ns / 1ps

module line_point_rasterizer #(
    parameter int COORD_BITS = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  lpr_pkg::in_word_t                 s_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lpr_pkg::out_word_t                m_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [0:0]                        cfg_index,
    input  logic [lpr_pkg::CANVAS_W-1:0]      cfg_data
);

    lpr_pkg::canvas_t canvas_reg, canvas_next;
    lpr_pkg::cmd_t    front_cmd, q_word;
    logic             q_not_full, q_not_empty, q_pop, push;

    assign cfg_ready = 1'b1;
    assign s_ready   = q_not_full;
    assign push      = s_valid && q_not_full;

    // canvas register writes
    always_comb begin
        canvas_next = canvas_reg;
        if (cfg_valid) begin
            case (cfg_index)
                lpr_pkg::CFG_CANVAS_WIDTH:  canvas_next.width  = cfg_data;
                lpr_pkg::CFG_CANVAS_HEIGHT: canvas_next.height = cfg_data;
                default:                    canvas_next = canvas_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            canvas_reg.width  <= lpr_pkg::CANVAS_W'(64);
            canvas_reg.height <= lpr_pkg::CANVAS_W'(64);
        end else begin
            canvas_reg <= canvas_next;
        end
    end

    // command classification
    lpr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .s_word(s_word),
        .cmd   (front_cmd)
    );

    // decoupling queue
    lpr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_word(front_cmd),
        .not_full (q_not_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .pop_word (q_word)
    );

    // line walker
    lpr_walk u_walk (
        .aclk   (aclk),
        .aresetn(aresetn),
        .canvas (canvas_reg),
        .q_valid(q_not_empty),
        .q_word (q_word),
        .q_pop  (q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_word (m_word)
    );

endmodule

>>> verif/line_point_rasterizer_tb.sv
// self-checking testbench for the line point rasterizer: directed table then random lines
`timescale 1ns / 1ps

module line_point_rasterizer_tb;

    localparam int COORD_W = lpr_pkg::COORD_W;
    localparam int CANVAS_W = lpr_pkg::CANVAS_W;
    localparam int MAX_POINTS = 1 << COORD_W;
    localparam int MAX_WAIT = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES = 8;
    localparam int LINES_PER_PHASE = 54;
    localparam int unsigned TIMEOUT_NS = 10_000_000;

    // one row of the directed table
    typedef struct {
        logic [CANVAS_W-1:0] cols;
        logic [CANVAS_W-1:0] rows;
        lpr_pkg::in_word_t   cmd;
        bit                  typed;
        lpr_pkg::out_word_t  point;
    } plan_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    lpr_pkg::in_word_t   s_word = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    lpr_pkg::out_word_t  m_word;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [0:0]          cfg_index = lpr_pkg::CFG_CANVAS_WIDTH;
    logic [CANVAS_W-1:0] cfg_data = '0;

    // canvas as the block should hold it, and points still to come
    logic [CANVAS_W-1:0] canvas_cols = 7'd64;
    logic [CANVAS_W-1:0] canvas_rows = 7'd64;
    lpr_pkg::out_word_t  pending_points[$];
    int                  mismatch_count = 0;
    bit                  steady_flow = 1'b0;
    int                  stall_left = 0;
    plan_row_t           plan[$];

    line_point_rasterizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // walk the line with the error term and queue every point up to the end point
    function automatic void trace_line(input lpr_pkg::in_word_t cmd);
        int                 cx, cy, tx, ty, span_x, span_y, step_x, step_y, err, err2, n;
        bit                 at_end;
        lpr_pkg::out_word_t pt;
        cx = cmd.start_x;
        cy = cmd.start_y;
        tx = cmd.end_x;
        ty = cmd.end_y;
        span_x = (tx > cx) ? tx - cx : cx - tx;
        span_y = (ty > cy) ? cy - ty : ty - cy;
        step_x = (cx < tx) ? 1 : -1;
        step_y = (cy < ty) ? 1 : -1;
        err = span_x + span_y;
        for (n = 0; n < MAX_POINTS; n++) begin
            at_end = (cx == tx) && (cy == ty);
            pt.point_x = cx[COORD_W-1:0];
            pt.point_y = cy[COORD_W-1:0];
            pt.inside_res = (cx < int'(canvas_cols)) && (cy < int'(canvas_rows));
            pt.point_color = cmd.line_color;
            pt.last = at_end;
            pending_points.push_back(pt);
            if (at_end) break;
            err2 = 2 * err;
            if (err2 >= span_y) begin
                err += span_y;
                cx += step_x;
            end
            if (err2 <= span_x) begin
                err += span_x;
                cy += step_y;
            end
        end
    endfunction

    // table row whose points come from the walk above
    function automatic plan_row_t line_row(input int cols, input int rows, input int sx,
                                           input int sy, input int ex, input int ey,
                                           input logic [31:0] colour);
        plan_row_t r;
        r.cols = cols[CANVAS_W-1:0];
        r.rows = rows[CANVAS_W-1:0];
        r.cmd = '{start_x: sx[5:0], start_y: sy[5:0], end_x: ex[5:0], end_y: ey[5:0],
                  line_color: colour};
        r.typed = 1'b0;
        r.point = '0;
        return r;
    endfunction

    // single-point line with its one result written out by hand
    function automatic plan_row_t dot_row(input int cols, input int rows, input int x,
                                          input int y, input logic [31:0] colour,
                                          input bit in_canvas);
        plan_row_t r;
        r = line_row(cols, rows, x, y, x, y, colour);
        r.typed = 1'b1;
        r.point = '{point_x: x[5:0], point_y: y[5:0], inside_res: in_canvas,
                    point_color: colour, last: 1'b1};
        return r;
    endfunction

    // random line, biased towards the awkward shapes
    function automatic lpr_pkg::in_word_t random_line();
        lpr_pkg::in_word_t c;
        int                sx, sy, ex, ey, len;
        bit                neg_x, neg_y;
        sx = $urandom_range(0, 63);
        sy = $urandom_range(0, 63);
        ex = $urandom_range(0, 63);
        ey = $urandom_range(0, 63);
        case ($urandom_range(0, 9))
            0: begin
                ex = sx;
                ey = sy;
            end
            1: ey = sy;
            2: ex = sx;
            3: begin
                len = $urandom_range(0, 63);
                neg_x = 1'($urandom_range(0, 1));
                neg_y = 1'($urandom_range(0, 1));
                sx = neg_x ? $urandom_range(len, 63) : $urandom_range(0, 63 - len);
                sy = neg_y ? $urandom_range(len, 63) : $urandom_range(0, 63 - len);
                ex = neg_x ? sx - len : sx + len;
                ey = neg_y ? sy - len : sy + len;
            end
            4: begin
                ex = sx + int'($urandom_range(0, 6)) - 3;
                ey = sy + int'($urandom_range(0, 6)) - 3;
                if (ex < 0) ex = 0;
                if (ex > 63) ex = 63;
                if (ey < 0) ey = 0;
                if (ey > 63) ey = 63;
            end
            default: ;
        endcase
        c.start_x = sx[5:0];
        c.start_y = sy[5:0];
        c.end_x = ex[5:0];
        c.end_y = ey[5:0];
        c.line_color = $urandom;
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    // offer one line command, queue its points once the word is taken
    task automatic send_line(input lpr_pkg::in_word_t cmd, input bit typed,
                             input lpr_pkg::out_word_t point);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_word <= cmd;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (typed) pending_points.push_back(point);
        else trace_line(cmd);
    endtask

    // hold the sender until every queued point has come out
    task automatic drain_points();
        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CANVAS_W-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == lpr_pkg::CFG_CANVAS_WIDTH) canvas_cols = value;
        else canvas_rows = value;
    endtask

    // canvas is only changed with the block idle
    task automatic set_canvas(input logic [CANVAS_W-1:0] cols,
                              input logic [CANVAS_W-1:0] rows);
        drain_points();
        write_reg(lpr_pkg::CFG_CANVAS_WIDTH, cols);
        write_reg(lpr_pkg::CFG_CANVAS_HEIGHT, rows);
        cfg_valid <= 1'b0;
    endtask

    // result side: fresh stall drawn after every accepted word
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 1;
        end else if (m_valid && m_ready) begin
            stall_left = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
            m_ready <= (stall_left == 0);
        end else if (!m_ready) begin
            if (stall_left <= 1) m_ready <= 1'b1;
            else stall_left = stall_left - 1;
        end
    end

    // compare each point word with the oldest expectation
    always @(posedge aclk) begin : check_points
        lpr_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                report_mismatch("point with no line pending, x", 32'(m_word.point_x), '0);
            end else begin
                want = pending_points.pop_front();
                if (m_word.point_x !== want.point_x)
                    report_mismatch("point_x", 32'(m_word.point_x), 32'(want.point_x));
                if (m_word.point_y !== want.point_y)
                    report_mismatch("point_y", 32'(m_word.point_y), 32'(want.point_y));
                if (m_word.inside_res !== want.inside_res)
                    report_mismatch("inside_res", 32'(m_word.inside_res),
                                    32'(want.inside_res));
                if (m_word.point_color !== want.point_color)
                    report_mismatch("point_color", m_word.point_color, want.point_color);
                if (m_word.last !== want.last)
                    report_mismatch("last", 32'(m_word.last), 32'(want.last));
            end
        end
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d points outstanding", pending_points.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int i, p, k;
        logic [CANVAS_W-1:0] cols, rows;

        // directed lines: corners, octants, axes, empty and oversized canvas
        plan.push_back(dot_row(64, 64, 0, 0, 32'h0000_0000, 1'b1));
        plan.push_back(dot_row(64, 64, 63, 63, 32'hFFFF_FFFF, 1'b1));
        plan.push_back(line_row(64, 64, 0, 0, 63, 63, 32'h1234_5678));
        plan.push_back(line_row(64, 64, 63, 63, 0, 0, 32'h8765_4321));
        plan.push_back(line_row(64, 64, 63, 0, 0, 63, 32'hA5A5_A5A5));
        plan.push_back(line_row(64, 64, 0, 63, 63, 0, 32'h5A5A_5A5A));
        plan.push_back(line_row(64, 64, 0, 17, 63, 17, 32'hFF00_0000));
        plan.push_back(line_row(64, 64, 63, 40, 0, 40, 32'h00FF_0000));
        plan.push_back(line_row(64, 64, 9, 0, 9, 63, 32'h0000_FF00));
        plan.push_back(line_row(64, 64, 50, 63, 50, 0, 32'h0000_00FF));
        plan.push_back(line_row(64, 64, 3, 5, 60, 20, 32'hDEAD_BEEF));
        plan.push_back(line_row(64, 64, 60, 20, 3, 5, 32'hCAFE_F00D));
        plan.push_back(line_row(64, 64, 5, 3, 20, 60, 32'h0F0F_0F0F));
        plan.push_back(line_row(64, 64, 20, 60, 5, 3, 32'hF0F0_F0F0));
        plan.push_back(line_row(64, 64, 10, 10, 11, 12, 32'h0102_0304));
        plan.push_back(dot_row(0, 64, 5, 5, 32'h1111_1111, 1'b0));
        plan.push_back(dot_row(64, 0, 0, 0, 32'h2222_2222, 1'b0));
        plan.push_back(line_row(0, 0, 0, 0, 63, 31, 32'h3333_3333));
        plan.push_back(dot_row(127, 127, 63, 63, 32'h4444_4444, 1'b1));
        plan.push_back(line_row(127, 127, 0, 63, 63, 0, 32'h5555_5555));
        plan.push_back(dot_row(1, 1, 0, 0, 32'h6666_6666, 1'b1));
        plan.push_back(dot_row(1, 1, 1, 0, 32'h7777_7777, 1'b0));
        plan.push_back(dot_row(1, 1, 0, 1, 32'h8888_8888, 1'b0));
        plan.push_back(line_row(1, 1, 0, 0, 2, 2, 32'h9999_9999));
        plan.push_back(line_row(40, 20, 0, 10, 63, 30, 32'hAAAA_AAAA));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        wait (aresetn);
        @(posedge aclk);

        for (i = 0; i < plan.size(); i++) begin
            if (plan[i].cols != canvas_cols || plan[i].rows != canvas_rows)
                set_canvas(plan[i].cols, plan[i].rows);
            send_line(plan[i].cmd, plan[i].typed, plan[i].point);
        end

        // random lines over a range of canvas sizes, extremes first
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin cols = 7'd64;  rows = 7'd64;  end
                1: begin cols = 7'd127; rows = 7'd127; end
                2: begin cols = 7'd0;   rows = 7'd0;   end
                3: begin cols = 7'd1;   rows = 7'd64;  end
                4: begin cols = 7'd64;  rows = 7'd1;   end
                default: begin
                    cols = CANVAS_W'($urandom_range(0, 127));
                    rows = CANVAS_W'($urandom_range(0, 127));
                end
            endcase
            set_canvas(cols, rows);
            for (k = 0; k < LINES_PER_PHASE; k++) begin
                if (k % 18 == 0) steady_flow = ($urandom_range(0, 3) == 0);
                if (p == 3 && k == 27) drain_points();
                send_line(random_line(), 1'b0, '0);
            end
        end

        drain_points();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
